FILE: sv/lcr_pkg.sv
// shared constants and types for the load cell reader
package lcr_pkg;

    // fixed field widths
    localparam int HALF_W   = 16;
    localparam int GAIN_W   = 32;
    localparam int AVG_W    = 24;
    localparam int WEIGHT_W = 16;
    localparam int CFG_W    = 32;

    // defaults for the top level parameters
    localparam int READINGS_AVERAGED_DEFAULT = 10;
    localparam int DATA_BITS_DEFAULT         = 24;

    // register reset values
    localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd80;
    localparam logic [GAIN_W-1:0] GAIN_RESET        = 32'd389;

    // register indexes
    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_GAIN        = 1'b1;

    // per-tick flags leaving the serial sequencer
    typedef struct packed {
        logic sck;
        logic busy;
        logic done;
        logic capture;
    } lcr_flags_t;

endpackage

FILE: sv/lcr_serial.sv
// serial clock sequencer, bit capture, reading accumulation and tare request tracking
module lcr_serial
    import lcr_pkg::*;
#(
    parameter int READINGS_AVERAGED = READINGS_AVERAGED_DEFAULT,
    parameter int DATA_BITS         = DATA_BITS_DEFAULT,
    parameter int CNT_W             = $clog2(READINGS_AVERAGED + 1),
    parameter int SUM_W             = DATA_BITS + CNT_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              dout_level,
    input  logic              tare_request,
    input  logic [HALF_W-1:0] half_period,
    output lcr_flags_t        flags,
    output logic [SUM_W-1:0]  sum_total
);

    localparam int BIT_W = $clog2(DATA_BITS + 1);

    localparam logic [2:0] PH_WAIT    = 3'd0;
    localparam logic [2:0] PH_HIGH    = 3'd1;
    localparam logic [2:0] PH_LOW     = 3'd2;
    localparam logic [2:0] PH_EXTRA   = 3'd3;
    localparam logic [2:0] PH_RECOVER = 3'd4;

    logic [2:0]           phase_reg,   phase_next;
    logic [HALF_W-1:0]    tick_reg,    tick_next;
    logic [BIT_W-1:0]     bit_reg,     bit_next;
    logic [DATA_BITS-1:0] shift_reg,   shift_next;
    logic [CNT_W-1:0]     count_reg,   count_next;
    logic [SUM_W-1:0]     sum_reg,     sum_next;
    logic                 pending_reg, pending_next;

    logic [HALF_W-1:0]    hp;
    logic [HALF_W:0]      tick_inc;
    logic                 half_end;
    logic [HALF_W-1:0]    tick_after;
    logic [BIT_W:0]       bit_inc;
    logic [CNT_W:0]       count_inc;
    logic [DATA_BITS-1:0] reading;
    logic [SUM_W-1:0]     sum_new;
    logic                 pend;

    // half period timing, zero acts as one
    assign hp         = (half_period == '0) ? HALF_W'(1) : half_period;
    assign tick_inc   = {1'b0, tick_reg} + (HALF_W + 1)'(1);
    assign half_end   = (tick_inc >= {1'b0, hp});
    assign tick_after = half_end ? '0 : tick_inc[HALF_W-1:0];

    // counters and the offset binary reading
    assign bit_inc   = {1'b0, bit_reg} + (BIT_W + 1)'(1);
    assign count_inc = {1'b0, count_reg} + (CNT_W + 1)'(1);
    assign reading   = {~shift_reg[DATA_BITS-1], shift_reg[DATA_BITS-2:0]};
    assign sum_new   = sum_reg + SUM_W'(reading);
    assign pend      = pending_reg | tare_request;
    assign sum_total = sum_new;

    // phase sequencing
    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        pending_next = pend;
        flags        = '0;
        case (phase_reg)
            PH_WAIT:
            begin
                if (!dout_level)
                begin
                    phase_next = PH_HIGH;
                    tick_next  = '0;
                    bit_next   = '0;
                    shift_next = '0;
                end
            end
            PH_HIGH:
            begin
                flags.sck  = 1'b1;
                flags.busy = 1'b1;
                tick_next  = tick_after;
                if (half_end)
                begin
                    phase_next = PH_LOW;
                end
            end
            PH_LOW:
            begin
                flags.busy = 1'b1;
                tick_next  = tick_after;
                if (tick_reg == '0)
                begin
                    shift_next = {shift_reg[DATA_BITS-2:0], dout_level};
                end
                if (half_end)
                begin
                    bit_next   = bit_inc[BIT_W-1:0];
                    phase_next = (bit_inc >= (BIT_W + 1)'(DATA_BITS)) ? PH_EXTRA : PH_HIGH;
                end
            end
            PH_EXTRA:
            begin
                flags.sck  = 1'b1;
                flags.busy = 1'b1;
                tick_next  = tick_after;
                if (half_end)
                begin
                    phase_next = PH_RECOVER;
                    if (count_inc >= (CNT_W + 1)'(READINGS_AVERAGED))
                    begin
                        flags.done    = 1'b1;
                        flags.capture = pend;
                        pending_next  = 1'b0;
                        sum_next      = '0;
                        count_next    = '0;
                    end
                    else
                    begin
                        sum_next   = sum_new;
                        count_next = count_inc[CNT_W-1:0];
                    end
                end
            end
            PH_RECOVER:
            begin
                tick_next = tick_after;
                if (half_end)
                begin
                    phase_next = PH_WAIT;
                end
            end
            default:
            begin
                phase_next = PH_WAIT;
                tick_next  = '0;
            end
        endcase
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_WAIT;
            tick_reg    <= '0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            pending_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            pending_reg <= pending_next;
        end
    end

endmodule

FILE: sv/load_cell_adc_reader_tare_scale.sv
// top level: load cell reader with averaging, tare and weight scaling
//
// One request on the input channel is one tick of the serial master: the
// sampled converter data line and a tare request. Every request gives one
// result request on the output channel carrying the serial clock level, the
// busy flag and, on the tick that finishes an average, the averaged raw
// reading with either a captured tare or the scaled weight in tenths.
// A result reaches out_valid after passing the stages below; one request is
// taken every cycle while in_stall is low. The path is five register
// stages: input, sequencer, divide by the reading count (reciprocal
// multiply), tare subtract and gain multiply, rounding and saturation.
// A stalled output holds its result while the stages behind it still fill;
// in_stall rises only once all five stages hold a result.
// Reset returns the sequencer to waiting for data ready, clears the sum, count, tare
// and pending tare request, and loads the register defaults (half period 80 ticks,
// gain 389 in Q16.16). The user must write registers through cfg_we, cfg_index and
// cfg_data only while no request is in flight; the block does not enforce this.
module load_cell_adc_reader_tare_scale
    import lcr_pkg::*;
#(
    parameter int READINGS_AVERAGED = READINGS_AVERAGED_DEFAULT,
    parameter int DATA_BITS         = DATA_BITS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                dout_level,
    input  logic                tare_request,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                sck_level,
    output logic                result_valid,
    output logic [AVG_W-1:0]    average_raw,
    output logic [WEIGHT_W-1:0] weight_tenths,
    output logic                above_tare,
    output logic                tare_captured,
    output logic                busy_res
);

    localparam int CNT_W     = $clog2(READINGS_AVERAGED + 1);
    localparam int SUM_W     = DATA_BITS + CNT_W;
    localparam int DIV_SHIFT = 32;
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam int QUOT_W    = SUM_W + RECIP_W;
    localparam int PROD_W    = AVG_W + GAIN_W;
    localparam int TRUNC_W   = PROD_W - 16;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((64'd1 << DIV_SHIFT)
        + 64'(READINGS_AVERAGED) - 64'd1) / 64'(READINGS_AVERAGED));

    // configuration registers
    logic [HALF_W-1:0] half_reg;
    logic [GAIN_W-1:0] gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= HALF_PERIOD_RESET;
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HALF_PERIOD: half_reg <= cfg_data[HALF_W-1:0];
                CFG_GAIN:        gain_reg <= cfg_data[GAIN_W-1:0];
                default:         gain_reg <= gain_reg;
            endcase
        end
    end

    // stage valids and readiness, a stage takes a request when empty or moving on
    logic s0_valid_reg, s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic rdy0, rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !s4_valid_reg || !out_stall;
    assign rdy3     = !s3_valid_reg || rdy4;
    assign rdy2     = !s2_valid_reg || rdy3;
    assign rdy1     = !s1_valid_reg || rdy2;
    assign rdy0     = !s0_valid_reg || rdy1;
    assign in_stall = !rdy0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy0) s0_valid_reg <= in_valid;
            if (rdy1) s1_valid_reg <= s0_valid_reg;
            if (rdy2) s2_valid_reg <= s1_valid_reg;
            if (rdy3) s3_valid_reg <= s2_valid_reg;
            if (rdy4) s4_valid_reg <= s3_valid_reg;
        end
    end

    // input register
    logic s0_dout_reg, s0_tare_reg;

    always_ff @(posedge clk)
    begin
        if (rdy0)
        begin
            s0_dout_reg <= dout_level;
            s0_tare_reg <= tare_request;
        end
    end

    // serial sequencer
    lcr_flags_t       seq_flags;
    logic [SUM_W-1:0] seq_sum;

    lcr_serial #(
        .READINGS_AVERAGED (READINGS_AVERAGED),
        .DATA_BITS         (DATA_BITS),
        .CNT_W             (CNT_W),
        .SUM_W             (SUM_W)
    ) u_serial (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (s0_valid_reg && rdy1),
        .dout_level   (s0_dout_reg),
        .tare_request (s0_tare_reg),
        .half_period  (half_reg),
        .flags        (seq_flags),
        .sum_total    (seq_sum)
    );

    lcr_flags_t       s1_flags_reg;
    logic [SUM_W-1:0] s1_sum_reg;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_flags_reg <= seq_flags;
            s1_sum_reg   <= seq_sum;
        end
    end

    // average by reciprocal multiply
    logic [QUOT_W-1:0] quot_full;
    lcr_flags_t        s2_flags_reg;
    logic [AVG_W-1:0]  s2_avg_reg;

    assign quot_full = QUOT_W'(s1_sum_reg) * QUOT_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_flags_reg <= s1_flags_reg;
            s2_avg_reg   <= s1_flags_reg.done ? AVG_W'(quot_full[DIV_SHIFT +: DATA_BITS]) : '0;
        end
    end

    // tare capture, compare and gain multiply
    logic [AVG_W-1:0]  tare_reg;
    logic [AVG_W-1:0]  diff;
    logic              above_next;
    lcr_flags_t        s3_flags_reg;
    logic [AVG_W-1:0]  s3_avg_reg;
    logic              s3_above_reg;
    logic [PROD_W-1:0] s3_prod_reg;

    assign diff       = s2_avg_reg - tare_reg;
    assign above_next = s2_flags_reg.done && !s2_flags_reg.capture && (s2_avg_reg > tare_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tare_reg <= '0;
        end
        else if (rdy3 && s2_valid_reg && s2_flags_reg.done && s2_flags_reg.capture)
        begin
            tare_reg <= s2_avg_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            s3_flags_reg <= s2_flags_reg;
            s3_avg_reg   <= s2_avg_reg;
            s3_above_reg <= above_next;
            s3_prod_reg  <= PROD_W'(diff) * PROD_W'(gain_reg);
        end
    end

    // rounding to tenths with saturation, output register
    logic [PROD_W-1:0]   rounded;
    logic [TRUNC_W-1:0]  trunc;
    logic [WEIGHT_W-1:0] weight_next;

    assign rounded     = s3_prod_reg + PROD_W'(32'h8000);
    assign trunc       = rounded[PROD_W-1:16];
    assign weight_next = !s3_above_reg ? '0
                       : (|trunc[TRUNC_W-1:WEIGHT_W]) ? '1
                       : trunc[WEIGHT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            sck_level     <= s3_flags_reg.sck;
            busy_res      <= s3_flags_reg.busy;
            result_valid  <= s3_flags_reg.done;
            tare_captured <= s3_flags_reg.done && s3_flags_reg.capture;
            average_raw   <= s3_avg_reg;
            above_tare    <= s3_above_reg;
            weight_tenths <= weight_next;
        end
    end

    assign out_valid = s4_valid_reg;

endmodule

FILE: verif/tb_load_cell_adc_reader_tare_scale.sv
// testbench for the load cell reader: converter stimulus, tick-level prediction and checking
`timescale 1ns / 1ps

module tb_load_cell_adc_reader_tare_scale;
    import lcr_pkg::*;

    localparam int N_AVG = READINGS_AVERAGED_DEFAULT;
    localparam int N_BITS = DATA_BITS_DEFAULT;
    localparam logic [AVG_W-1:0] SIGN_FLIP = {1'b1, {(AVG_W-1){1'b0}}};
    localparam int ITEMS_TARGET = 1650;

    // sequencer phases as the predictor tracks them
    typedef enum logic [2:0] {
        SEQ_WAIT,
        SEQ_HIGH,
        SEQ_LOW,
        SEQ_EXTRA,
        SEQ_RECOVER
    } seq_state_t;

    // one request on the input channel: one tick of the serial master
    typedef struct packed {
        logic dout;
        logic tare;
    } adc_tick_t;

    // one result request, field for field as on the output ports
    typedef struct packed {
        logic                sck;
        logic                done;
        logic [AVG_W-1:0]    avg;
        logic [WEIGHT_W-1:0] weight;
        logic                above;
        logic                captured;
        logic                busy;
    } reader_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic                cfg_index = CFG_HALF_PERIOD;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                dout_level = 1'b1;
    logic                tare_request = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                sck_level;
    logic                result_valid;
    logic [AVG_W-1:0]    average_raw;
    logic [WEIGHT_W-1:0] weight_tenths;
    logic                above_tare;
    logic                tare_captured;
    logic                busy_res;

    // requests waiting to be offered and results still owed by the block
    adc_tick_t      pending_ticks[$];
    reader_result_t expected_ticks[$];

    // predictor copy of the registers and sequencer state
    logic [HALF_W-1:0] mdl_half = HALF_PERIOD_RESET;
    logic [GAIN_W-1:0] mdl_gain = GAIN_RESET;
    seq_state_t        mdl_state = SEQ_WAIT;
    logic [15:0]       mdl_ticks = '0;
    logic [4:0]        mdl_bits = '0;
    logic [AVG_W-1:0]  mdl_shift = '0;
    logic [3:0]        mdl_nreads = '0;
    logic [27:0]       mdl_sum = '0;
    logic [AVG_W-1:0]  mdl_tare = '0;
    logic              mdl_tare_pend = 1'b0;

    // stimulus bookkeeping
    int frame_half = 80;
    int last_level = 0;
    int ticks_queued = 0;
    int send_gap = 0;
    int send_calm = 0;
    int recv_calm = 0;
    int stall_left = 0;
    int hold_left = 0;
    int results_seen = 0;
    logic hold_on = 1'b0;
    int phases_run = 0;

    // result tallies
    int mismatches = 0;
    int ticks_checked = 0;
    int n_averages = 0;
    int n_captures = 0;
    int n_above = 0;
    int n_saturated = 0;
    int n_zeroed = 0;

    always #6 clk = ~clk;

    load_cell_adc_reader_tare_scale u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .dout_level    (dout_level),
        .tare_request  (tare_request),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sck_level     (sck_level),
        .result_valid  (result_valid),
        .average_raw   (average_raw),
        .weight_tenths (weight_tenths),
        .above_tare    (above_tare),
        .tare_captured (tare_captured),
        .busy_res      (busy_res)
    );

    // one tick of a timed half; true when the half is over
    function automatic bit half_elapsed();
        logic [16:0] span;
        span = (mdl_half == '0) ? 17'd1 : {1'b0, mdl_half};
        if ({1'b0, mdl_ticks} + 17'd1 >= span)
        begin
            mdl_ticks = '0;
            return 1'b1;
        end
        mdl_ticks = mdl_ticks + 16'd1;
        return 1'b0;
    endfunction

    // expected outputs for one accepted tick, advancing the predictor
    function automatic reader_result_t predict_reader_tick(input logic dout, input logic tare);
        reader_result_t r;
        logic [AVG_W-1:0] reading;
        logic [27:0]      quot;
        logic [63:0]      scaled;
        r = '0;
        if (tare)
            mdl_tare_pend = 1'b1;
        case (mdl_state)
            SEQ_WAIT:
            begin
                if (!dout)
                begin
                    mdl_state = SEQ_HIGH;
                    mdl_ticks = '0;
                    mdl_bits = '0;
                    mdl_shift = '0;
                end
            end
            SEQ_HIGH:
            begin
                r.sck = 1'b1;
                r.busy = 1'b1;
                if (half_elapsed())
                    mdl_state = SEQ_LOW;
            end
            SEQ_LOW:
            begin
                r.busy = 1'b1;
                if (mdl_ticks == '0)
                    mdl_shift = {mdl_shift[AVG_W-2:0], dout};
                if (half_elapsed())
                begin
                    mdl_bits = mdl_bits + 5'd1;
                    mdl_state = (mdl_bits >= N_BITS) ? SEQ_EXTRA : SEQ_HIGH;
                end
            end
            SEQ_EXTRA:
            begin
                r.sck = 1'b1;
                r.busy = 1'b1;
                if (half_elapsed())
                begin
                    reading = mdl_shift ^ SIGN_FLIP;
                    mdl_sum = mdl_sum + {4'b0, reading};
                    mdl_nreads = mdl_nreads + 4'd1;
                    if (mdl_nreads >= N_AVG)
                    begin
                        quot = 28'(mdl_sum / N_AVG);
                        r.avg = quot[AVG_W-1:0];
                        r.done = 1'b1;
                        mdl_sum = '0;
                        mdl_nreads = '0;
                        if (mdl_tare_pend)
                        begin
                            mdl_tare = r.avg;
                            mdl_tare_pend = 1'b0;
                            r.captured = 1'b1;
                        end
                        else if (r.avg > mdl_tare)
                        begin
                            scaled = {40'b0, r.avg - mdl_tare} * {32'b0, mdl_gain} + 64'h8000;
                            scaled = scaled >> 16;
                            r.above = 1'b1;
                            r.weight = (scaled > 64'hFFFF) ? '1 : scaled[WEIGHT_W-1:0];
                        end
                    end
                    mdl_state = SEQ_RECOVER;
                end
            end
            SEQ_RECOVER:
            begin
                if (half_elapsed())
                    mdl_state = SEQ_WAIT;
            end
            default:
            begin
                mdl_state = SEQ_WAIT;
                mdl_ticks = '0;
            end
        endcase
        return r;
    endfunction

    // idle length for either side: mostly none, some short, a few long, calm stretches
    function automatic int pick_idle(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm = $urandom_range(30, 250);
            return 0;
        end
        if (r < 62)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    // one line per mismatch
    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("tick %0d: %s got 0x%0h expected 0x%0h", ticks_checked, what, got, want);
        mismatches++;
    endtask

    task automatic push_tick(input logic dout, input logic tare);
        adc_tick_t t;
        t.dout = dout;
        t.tare = tare;
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    // one well-formed conversion: ready low, the data bits on the sampled ticks,
    // noise on every tick the block ignores; tare_at indexes the frame tick
    task automatic push_frame(input logic [AVG_W-1:0] reading, input int tare_at);
        logic [AVG_W-1:0] word;
        int idx;
        int pos;
        word = reading ^ SIGN_FLIP;
        repeat ($urandom_range(0, 3))
            push_tick(1'b1, 1'b0);
        for (idx = 0; idx <= 50 * frame_half; idx++)
        begin
            pos = (idx - 1) % (2 * frame_half);
            if (idx == 0)
                push_tick(1'b0, tare_at == 0);
            else if (idx <= 48 * frame_half && pos == frame_half)
                push_tick(word[N_BITS - 1 - (idx - 1) / (2 * frame_half)], idx == tare_at);
            else
                push_tick(1'($urandom_range(0, 1)), idx == tare_at);
        end
    endtask

    // data line held high long enough to finish any reading and park in wait
    task automatic push_resync();
        repeat (50 * frame_half + 2)
            push_tick(1'b1, 1'b0);
    endtask

    // random line activity out of step with the protocol, then back in step
    task automatic push_noise(input int n);
        repeat (n)
            push_tick(1'($urandom_range(0, 1)), $urandom_range(0, 49) == 0);
        push_resync();
    endtask

    // level for a group of readings: extremes, the previous level again, or random
    function automatic int pick_level();
        int r;
        r = $urandom_range(0, 5);
        if (r == 0)
            last_level = 0;
        else if (r == 1)
            last_level = 24'hFFFFFF;
        else if (r > 3)
            last_level = $urandom_range(0, 24'hFFFFFF);
        return last_level;
    endfunction

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_HALF_PERIOD)
        begin
            mdl_half = data[HALF_W-1:0];
            frame_half = (data[HALF_W-1:0] == '0) ? 1 : int'(data[HALF_W-1:0]);
        end
        else
            mdl_gain = data[GAIN_W-1:0];
        @(negedge clk);
    endtask

    // wait until every request is taken and every result is back
    task automatic wait_idle();
        while (pending_ticks.size() != 0 || expected_ticks.size() != 0 || in_valid)
            @(posedge clk);
        repeat (6)
            @(posedge clk);
        @(negedge clk);
    endtask

    // request driver: predicts on acceptance, then offers the next tick or idles
    always @(posedge clk or negedge rst_n)
    begin : drive_ticks
        adc_tick_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            dout_level <= 1'b1;
            tare_request <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_ticks.push_back(predict_reader_tick(dout_level, tare_request));
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_ticks.size() != 0)
                begin
                    nxt = pending_ticks.pop_front();
                    in_valid <= 1'b1;
                    dout_level <= nxt.dout;
                    tare_request <= nxt.tare;
                    send_gap = pick_idle(send_calm);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted in cycles, so the pipeline fills and stalls its input
    always @(posedge clk or negedge rst_n)
    begin : hold_off
        if (!rst_n)
        begin
            hold_on <= 1'b0;
            hold_left = 0;
            results_seen = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                results_seen++;
            if (hold_left > 0)
                hold_left--;
            else if (out_valid && !out_stall && (results_seen == 400 || results_seen == 1200))
                hold_left = 60;
            hold_on <= (hold_left > 0);
        end
    end

    // result monitor: checks each result request and drives the output stall
    always @(posedge clk or negedge rst_n)
    begin : check_results
        reader_result_t seen;
        reader_result_t want;
        int n;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen = {sck_level, result_valid, average_raw, weight_tenths,
                        above_tare, tare_captured, busy_res};
                if (expected_ticks.size() == 0)
                    report_mismatch("result with nothing expected", seen, 0);
                else
                begin
                    want = expected_ticks.pop_front();
                    if (seen.sck != want.sck)
                        report_mismatch("sck_level", seen.sck, want.sck);
                    if (seen.done != want.done)
                        report_mismatch("result_valid", seen.done, want.done);
                    if (seen.avg != want.avg)
                        report_mismatch("average_raw", seen.avg, want.avg);
                    if (seen.weight != want.weight)
                        report_mismatch("weight_tenths", seen.weight, want.weight);
                    if (seen.above != want.above)
                        report_mismatch("above_tare", seen.above, want.above);
                    if (seen.captured != want.captured)
                        report_mismatch("tare_captured", seen.captured, want.captured);
                    if (seen.busy != want.busy)
                        report_mismatch("busy_res", seen.busy, want.busy);
                    if (want.done)
                    begin
                        n_averages++;
                        if (want.captured)
                            n_captures++;
                        else if (want.above)
                        begin
                            n_above++;
                            if (want.weight == '1)
                                n_saturated++;
                        end
                        else
                            n_zeroed++;
                    end
                end
                ticks_checked++;
            end
            if (hold_on)
            begin
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                n = pick_idle(recv_calm);
                out_stall <= (n > 0);
                stall_left = (n > 0) ? n - 1 : 0;
            end
        end
    end

    // stimulus: directed cases, then random phases of settings and conversions
    initial
    begin : stimulus
        int k;
        int f;
        int nfr;
        int level;
        int v;
        int hp;
        logic [CFG_W-1:0] rnd;

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: start one reading at the default half period
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        repeat (40)
            push_tick(1'($urandom_range(0, 1)), 1'b0);
        wait_idle();

        // zero half period acts as one: the open reading finishes with the line high,
        // nine conversions complete the average, tare request on the completing tick
        write_reg(CFG_HALF_PERIOD, 32'h0);
        push_resync();
        repeat (N_AVG - 2)
            push_frame(24'h000000, -1);
        push_frame(24'h000000, 49 * frame_half);
        wait_idle();

        // full scale above the tare with maximum gain saturates
        write_reg(CFG_GAIN, 32'hFFFF_FFFF);
        repeat (N_AVG)
            push_frame(24'hFFFFFF, -1);
        wait_idle();

        // largest half period, upper data bits ignored; only part of a pulse
        write_reg(CFG_HALF_PERIOD, {16'hA5A5, 16'hFFFF});
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        repeat (30)
            push_tick(1'($urandom_range(0, 1)), 1'b0);
        wait_idle();

        // random phases: new settings, then conversions with noise until the budget is spent
        while (ticks_queued < ITEMS_TARGET)
        begin
            if (phases_run == 0 || $urandom_range(0, 9) < 7)
            begin
                k = $urandom_range(0, 9);
                hp = (k < 5) ? 1 : (k < 8) ? 2 : (k < 9) ? $urandom_range(3, 6) : 0;
                rnd = $urandom;
                rnd[HALF_W-1:0] = HALF_W'(hp);
                write_reg(CFG_HALF_PERIOD, rnd);
            end
            if ($urandom_range(0, 9) < 6)
            begin
                k = $urandom_range(0, 5);
                rnd = (k == 0) ? GAIN_RESET :
                      (k == 1) ? 32'h0 :
                      (k == 2) ? 32'hFFFF_FFFF :
                      (k == 3) ? $urandom_range(1, 200000) : $urandom;
                write_reg(CFG_GAIN, rnd);
            end
            push_resync();
            nfr = $urandom_range(10, 25);
            level = pick_level();
            for (f = 0; f < nfr && ticks_queued < ITEMS_TARGET; f++)
            begin
                if (f % N_AVG == 0)
                    level = pick_level();
                if ($urandom_range(0, 9) == 0)
                    push_noise($urandom_range(1, 120));
                v = level + int'($urandom_range(0, 6)) - 3;
                if (v < 0)
                    v = 0;
                if (v > 24'hFFFFFF)
                    v = 24'hFFFFFF;
                push_frame(AVG_W'(v), ($urandom_range(0, 11) == 0) ?
                              int'($urandom_range(0, 49 * frame_half + 1)) : -1);
            end
            phases_run++;
            wait_idle();
        end

        repeat (12)
            @(posedge clk);
        if (expected_ticks.size() != 0)
            report_mismatch("results never arrived", expected_ticks.size(), 0);
        $display("checked %0d ticks and %0d averages: %0d tare captures, %0d above tare",
                 ticks_checked, n_averages, n_captures, n_above);
        $display("%0d saturated, %0d at or below tare, %0d random setting phases",
                 n_saturated, n_zeroed, phases_run);
        if (mismatches == 0)
            $display("load_cell_adc_reader_tare_scale: match");
        else
            $display("load_cell_adc_reader_tare_scale: mismatch");
        $finish;
    end

    // run limit, far beyond the slowest legal run
    initial
    begin
        #200_000_000;
        $display("timed out with %0d results still owed", expected_ticks.size());
        $display("load_cell_adc_reader_tare_scale: mismatch");
        $finish;
    end

endmodule
